/* sv/svbs_pkg.sv */
package svbs_pkg;

   // Fraction bits of every fixed-point value.
   localparam int FRAC = 16;
   // Width of a request or result coordinate.
   localparam int IW = 32;
   // Width of an intermediate; intermediates saturate to +-(2^(WW-1) - 1).
   localparam int WW = 48;

   typedef logic signed [WW-1:0] wide_type;

   localparam wide_type LIM = {1'b0, {(WW-1){1'b1}}};

   localparam logic signed [WW:0] S32_MAX = (WW+1)'(32'h7FFF_FFFF);
   localparam logic signed [WW:0] S32_MIN = -S32_MAX - (WW+1)'(1);
   localparam wide_type RAD_MAX = wide_type'(32'h7FFF_FFFF);

   localparam logic [15:0] TOL_RESET = 16'd7;

   // Unit latencies: the multiplier has four stages, the divider one bit per
   // stage plus entry and exit, the square root one result bit per stage plus entry.
   localparam int MUL_LAT = 4;
   localparam int DIV_LAT = WW + 1;
   localparam int SQRT_LAT = (WW + FRAC) / 2 + 1;
   localparam int TOTAL_LAT = 8 + 5 * MUL_LAT + 3 * DIV_LAT + 2 * SQRT_LAT;

   // Everything a request still needs further down the pipeline.
   typedef struct packed {
      logic signed [IW-1:0] nr;
      logic signed [IW-1:0] fr;
      logic signed [IW-1:0] nc;
      logic signed [IW-1:0] fc;
      logic [2:0][IW-1:0]   org;
      logic [2:0][IW-1:0]   dir;
      logic signed [IW:0]   diff;
      wide_type             dc;
      logic                 eq;
      logic [IW-1:0]        half;
      wide_type             eqdist;
      logic                 degen;
      wide_type             p4;
      wide_type             num;
      wide_type             s;
      wide_type             h;
      wide_type             base;
      wide_type             den;
      wide_type             fcb;
      wide_type             z1;
      wide_type             zh;
      wide_type             focus;
      wide_type             z2;
      wide_type             travel;
      wide_type             s2;
      wide_type             rad;
   } ctx_type;

   function automatic wide_type clampw(input logic signed [WW:0] v);
      if (v > $signed({1'b0, LIM})) begin
         return LIM;
      end else if (v < -$signed({1'b0, LIM})) begin
         return -LIM;
      end else begin
         return v[WW-1:0];
      end
   endfunction

endpackage

/* sv/svbs_mul.sv */
module svbs_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  svbs_pkg::ctx_type   in_ctx,
   input  svbs_pkg::wide_type  in_a,
   input  svbs_pkg::wide_type  in_b,
   output logic                out_valid,
   output svbs_pkg::ctx_type   out_ctx,
   output svbs_pkg::wide_type  out_p
);

   localparam int WW = svbs_pkg::WW;
   localparam int HW = WW / 2;
   localparam int PW = 2 * WW;
   localparam int NS = svbs_pkg::MUL_LAT;

   logic               valid_ff [NS];
   svbs_pkg::ctx_type  ctx_ff [NS];
   logic               neg_ff [NS-1];
   logic [WW-1:0]      ma_ff, mb_ff, ma_in, mb_in;
   logic [WW-1:0]      pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [PW-1:0]      sum_ff, sum_in, rnd, sh;
   logic [WW-1:0]      mag;
   svbs_pkg::wide_type p_ff, p_in;

   always_comb begin
      ma_in = in_a[WW-1] ? WW'(-in_a) : WW'(in_a);
      mb_in = in_b[WW-1] ? WW'(-in_b) : WW'(in_b);
      sum_in = PW'(pp00_ff) + (PW'(pp01_ff) << HW) + (PW'(pp10_ff) << HW)
             + (PW'(pp11_ff) << WW);
      // Round to nearest, ties away from zero, on the magnitude.
      rnd = sum_ff + (PW'(1) << (svbs_pkg::FRAC - 1));
      sh = rnd >> svbs_pkg::FRAC;
      mag = (sh > PW'(svbs_pkg::LIM)) ? WW'(svbs_pkg::LIM) : sh[WW-1:0];
      p_in = neg_ff[NS-2] ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff[0] <= in_ctx;
      for (int i = 1; i < NS; i++) begin
         ctx_ff[i] <= ctx_ff[i-1];
      end
      neg_ff[0] <= in_a[WW-1] ^ in_b[WW-1];
      for (int i = 1; i < NS-1; i++) begin
         neg_ff[i] <= neg_ff[i-1];
      end
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      pp00_ff <= WW'(ma_ff[HW-1:0]) * WW'(mb_ff[HW-1:0]);
      pp01_ff <= WW'(ma_ff[HW-1:0]) * WW'(mb_ff[WW-1:HW]);
      pp10_ff <= WW'(ma_ff[WW-1:HW]) * WW'(mb_ff[HW-1:0]);
      pp11_ff <= WW'(ma_ff[WW-1:HW]) * WW'(mb_ff[WW-1:HW]);
      sum_ff <= sum_in;
      p_ff <= p_in;
   end

   assign out_valid = valid_ff[NS-1];
   assign out_ctx = ctx_ff[NS-1];
   assign out_p = p_ff;

endmodule

/* sv/svbs_div.sv */
module svbs_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  svbs_pkg::ctx_type   in_ctx,
   input  svbs_pkg::wide_type  in_a,
   input  svbs_pkg::wide_type  in_b,
   output logic                out_valid,
   output svbs_pkg::ctx_type   out_ctx,
   output svbs_pkg::wide_type  out_q
);

   localparam int WW = svbs_pkg::WW;
   localparam int FRAC = svbs_pkg::FRAC;
   localparam int NW = WW + FRAC;
   localparam int QB = WW - 1;
   localparam int CW = WW + QB;

   logic               valid_ff [QB+1];
   svbs_pkg::ctx_type  ctx_ff [QB+1];
   logic [NW-1:0]      rem_ff [QB];
   logic [WW-1:0]      d_ff [QB];
   logic [QB-1:0]      q_ff [QB+1];
   logic               neg_ff [QB+1];
   logic               sat_ff [QB+1];
   logic [WW-1:0]      n_in, d_in;
   logic               sat_in;
   logic [WW-1:0]      qmag;
   logic               out_valid_ff;
   svbs_pkg::ctx_type  out_ctx_ff;
   svbs_pkg::wide_type q_out_ff, q_out_in;

   always_comb begin
      n_in = in_a[WW-1] ? WW'(-in_a) : WW'(in_a);
      d_in = in_b[WW-1] ? WW'(-in_b) : WW'(in_b);
      // The quotient saturates when it reaches 2^QB; a zero divisor lands here too.
      sat_in = (CW'(n_in) << FRAC) >= (CW'(d_in) << QB);
      qmag = sat_ff[QB] ? WW'(svbs_pkg::LIM) : {1'b0, q_ff[QB]};
      q_out_in = neg_ff[QB] ? -$signed(qmag) : $signed(qmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         out_valid_ff <= valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff[0] <= in_ctx;
      rem_ff[0] <= NW'(n_in) << FRAC;
      d_ff[0] <= d_in;
      q_ff[0] <= '0;
      neg_ff[0] <= in_a[WW-1] ^ in_b[WW-1];
      sat_ff[0] <= sat_in;
      out_ctx_ff <= ctx_ff[QB];
      q_out_ff <= q_out_in;
   end

   for (genvar k = 0; k < QB; k++) begin : g_bit
      localparam int SH = QB - 1 - k;
      logic [CW-1:0] dsh;
      logic          take;

      always_comb begin
         dsh = CW'(d_ff[k]) << SH;
         take = CW'(rem_ff[k]) >= dsh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         ctx_ff[k+1] <= ctx_ff[k];
         q_ff[k+1] <= {q_ff[k][QB-2:0], take};
         neg_ff[k+1] <= neg_ff[k];
         sat_ff[k+1] <= sat_ff[k];
      end

      if (k < QB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= take ? rem_ff[k] - dsh[NW-1:0] : rem_ff[k];
            d_ff[k+1] <= d_ff[k];
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_ctx = out_ctx_ff;
   assign out_q = q_out_ff;

endmodule

/* sv/svbs_sqrt.sv */
module svbs_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  svbs_pkg::ctx_type   in_ctx,
   input  svbs_pkg::wide_type  in_x,
   output logic                out_valid,
   output svbs_pkg::ctx_type   out_ctx,
   output svbs_pkg::wide_type  out_r
);

   localparam int WW = svbs_pkg::WW;
   localparam int FRAC = svbs_pkg::FRAC;
   localparam int VB = WW - 1 + FRAC;
   localparam int RB = (VB + 1) / 2;
   localparam int TW = 2 * RB + 2;

   logic              valid_ff [RB+1];
   svbs_pkg::ctx_type ctx_ff [RB+1];
   logic [VB-1:0]     rem_ff [RB];
   logic [RB-1:0]     res_ff [RB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   // The operand is never negative, so its low WW-1 bits are the whole value.
   always_ff @(posedge clock) begin
      ctx_ff[0] <= in_ctx;
      rem_ff[0] <= {in_x[WW-2:0], FRAC'(0)};
      res_ff[0] <= '0;
   end

   for (genvar k = 0; k < RB; k++) begin : g_bit
      localparam int B = RB - 1 - k;
      logic [TW-1:0] trial;
      logic          take;

      // (res + 2^B)^2 - res^2 = res * 2^(B+1) + 2^(2B)
      always_comb begin
         trial = (TW'(res_ff[k]) << (B + 1)) + (TW'(1) << (2 * B));
         take = TW'(rem_ff[k]) >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         ctx_ff[k+1] <= ctx_ff[k];
         res_ff[k+1] <= take ? (res_ff[k] | (RB'(1) << B)) : res_ff[k];
      end

      if (k < RB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= take ? rem_ff[k] - trial[VB-1:0] : rem_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[RB];
   assign out_ctx = ctx_ff[RB];
   assign out_r = $signed({{(WW-RB){1'b0}}, res_ff[RB]});

endmodule

/* sv/shadow_volume_bounding_sphere.sv */
// Bounding sphere of a shadow frustum, one request per clock. busy is always
// low, so a request is taken on every cycle that start is high, and its
// result appears on the rsp_ ports, marked by rsp_valid for one cycle; the
// receiver cannot stall it. The pipeline depth is set by the unequal-radii
// path: three pipelined long dividers (49 stages each, one quotient bit per
// stage), two pipelined square roots (33 stages each) and five four-stage
// multipliers, chained with eight short arithmetic stages. Requests with
// equal radii travel the same pipeline and take the same time. csr_wr_data
// sets the radius tolerance; the user writes it only while the pipeline is
// empty, and the block itself does not enforce this.
module shadow_volume_bounding_sphere (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_near_radius,
   input  logic signed [31:0] req_far_radius,
   input  logic signed [31:0] req_near_cast,
   input  logic signed [31:0] req_far_cast,
   input  logic signed [31:0] req_cast_x,
   input  logic signed [31:0] req_cast_y,
   input  logic signed [31:0] req_cast_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_center_x,
   output logic signed [31:0] rsp_center_y,
   output logic signed [31:0] rsp_center_z,
   output logic [30:0]        rsp_sphere_radius,
   output logic               rsp_degenerate
);

   localparam int WW = svbs_pkg::WW;
   localparam int IW = svbs_pkg::IW;

   logic [15:0]        tol_ff;
   logic               v0_ff, v2_ff, v5_ff, v8_ff, v11_ff, v13_ff, v15_ff;
   svbs_pkg::ctx_type  c0_ff, c2_ff, c5_ff, c8_ff, c11_ff, c13_ff, c15_ff;
   svbs_pkg::ctx_type  c0_in, c2_in, c5_in, c8_in, c11_in, c13_in, c15_in;
   logic               v1, v3, v4, v6, v7, v9, v10, v12, v14, v16;
   svbs_pkg::ctx_type  c1, c3, c3m, c4, c6, c7, c9, c10, c12, c14, c16;
   svbs_pkg::wide_type p1, p2, p3, p4, h3, base4, t6, z17, u9, focus10, sq12, rad14;
   svbs_pkg::wide_type px, py, pz;
   logic [IW:0]        adiff, adc;
   logic signed [IW:0] dcs;

   logic               out_valid_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic [30:0]        rad_ff, rad_in;
   logic               degen_ff;

   function automatic logic signed [31:0] sat32(input logic signed [WW:0] v);
      if (v > svbs_pkg::S32_MAX) begin
         return 32'sh7FFF_FFFF;
      end else if (v < svbs_pkg::S32_MIN) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= svbs_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // Request capture; the equal-radii result is worked out here as well.
   always_comb begin
      c0_in = '0;
      c0_in.nr = req_near_radius;
      c0_in.fr = req_far_radius;
      c0_in.nc = req_near_cast;
      c0_in.fc = req_far_cast;
      c0_in.org = {req_cast_z, req_cast_y, req_cast_x};
      c0_in.dir = {req_dir_z, req_dir_y, req_dir_x};
      c0_in.diff = (IW+1)'(req_near_radius) - (IW+1)'(req_far_radius);
      adiff = c0_in.diff[IW] ? (IW+1)'(-c0_in.diff) : (IW+1)'(c0_in.diff);
      c0_in.eq = adiff <= (IW+1)'(tol_ff);
      dcs = (IW+1)'(req_far_cast) - (IW+1)'(req_near_cast);
      c0_in.dc = WW'(dcs);
      adc = dcs[IW] ? (IW+1)'(-dcs) : (IW+1)'(dcs);
      c0_in.half = adc[IW:1];
      c0_in.eqdist = WW'(req_near_cast) + $signed(WW'(c0_in.half));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v2_ff <= 1'b0;
         v5_ff <= 1'b0;
         v8_ff <= 1'b0;
         v11_ff <= 1'b0;
         v13_ff <= 1'b0;
         v15_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v2_ff <= v1;
         v5_ff <= v4;
         v8_ff <= v7;
         v11_ff <= v10;
         v13_ff <= v12;
         v15_ff <= v14;
         out_valid_ff <= v16;
      end
   end

   always_ff @(posedge clock) begin
      c0_ff <= c0_in;
      c2_ff <= c2_in;
      c5_ff <= c5_in;
      c8_ff <= c8_in;
      c11_ff <= c11_in;
      c13_ff <= c13_in;
      c15_ff <= c15_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      rad_ff <= rad_in;
      degen_ff <= c16.degen;
   end

   // Products for the apex numerator and the frustum height.
   svbs_mul u_m1a (
      .clock(clock), .reset(reset), .in_valid(v0_ff), .in_ctx(c0_ff),
      .in_a(WW'(c0_ff.nc)), .in_b(WW'(c0_ff.fr)),
      .out_valid(v1), .out_ctx(c1), .out_p(p1)
   );
   svbs_mul u_m1b (
      .clock(clock), .reset(reset), .in_valid(v0_ff), .in_ctx(c0_ff),
      .in_a(WW'(c0_ff.fc)), .in_b(WW'(c0_ff.nr)),
      .out_valid(), .out_ctx(), .out_p(p2)
   );
   svbs_mul u_m1c (
      .clock(clock), .reset(reset), .in_valid(v0_ff), .in_ctx(c0_ff),
      .in_a(c0_ff.dc), .in_b(c0_ff.dc),
      .out_valid(), .out_ctx(), .out_p(p3)
   );
   svbs_mul u_m1d (
      .clock(clock), .reset(reset), .in_valid(v0_ff), .in_ctx(c0_ff),
      .in_a(WW'(c0_ff.fr)), .in_b(WW'(c0_ff.fr)),
      .out_valid(), .out_ctx(), .out_p(p4)
   );

   always_comb begin
      c2_in = c1;
      c2_in.p4 = p4;
      c2_in.num = svbs_pkg::clampw((WW+1)'(p1) - (WW+1)'(p2));
      c2_in.s = svbs_pkg::clampw((WW+1)'(p3) + (WW+1)'(p4));
   end

   svbs_sqrt u_sq1 (
      .clock(clock), .reset(reset), .in_valid(v2_ff), .in_ctx(c2_ff),
      .in_x(c2_ff.s), .out_valid(v3), .out_ctx(c3), .out_r(h3)
   );

   always_comb begin
      c3m = c3;
      c3m.h = h3;
   end

   svbs_div u_dv1 (
      .clock(clock), .reset(reset), .in_valid(v3), .in_ctx(c3m),
      .in_a(c3m.num), .in_b(WW'(c3m.diff)),
      .out_valid(v4), .out_ctx(c4), .out_q(base4)
   );

   always_comb begin
      c5_in = c4;
      c5_in.base = base4;
      c5_in.den = svbs_pkg::clampw((WW+1)'(c4.nc) + (WW+1)'(base4));
      c5_in.fcb = svbs_pkg::clampw((WW+1)'(c4.fc) + (WW+1)'(base4));
      c5_in.degen = !c4.eq && (c4.dc == '0 || c5_in.den == '0);
   end

   svbs_mul u_m2 (
      .clock(clock), .reset(reset), .in_valid(v5_ff), .in_ctx(c5_ff),
      .in_a(c5_ff.den), .in_b(c5_ff.h),
      .out_valid(v6), .out_ctx(c6), .out_p(t6)
   );

   svbs_div u_dv2 (
      .clock(clock), .reset(reset), .in_valid(v6), .in_ctx(c6),
      .in_a(t6), .in_b(c6.dc),
      .out_valid(v7), .out_ctx(c7), .out_q(z17)
   );

   always_comb begin
      c8_in = c7;
      c8_in.z1 = z17;
      c8_in.zh = svbs_pkg::clampw((WW+1)'(z17) + (WW+1)'(c7.h >>> 1));
   end

   svbs_mul u_m3 (
      .clock(clock), .reset(reset), .in_valid(v8_ff), .in_ctx(c8_ff),
      .in_a(c8_ff.z1), .in_b(c8_ff.zh),
      .out_valid(v9), .out_ctx(c9), .out_p(u9)
   );

   svbs_div u_dv3 (
      .clock(clock), .reset(reset), .in_valid(v9), .in_ctx(c9),
      .in_a(u9), .in_b(c9.den),
      .out_valid(v10), .out_ctx(c10), .out_q(focus10)
   );

   always_comb begin
      c11_in = c10;
      c11_in.focus = focus10;
      c11_in.z2 = svbs_pkg::clampw((WW+1)'(c10.fcb) - (WW+1)'(focus10));
      c11_in.travel = svbs_pkg::clampw((WW+1)'(focus10) - (WW+1)'(c10.base));
   end

   svbs_mul u_m4 (
      .clock(clock), .reset(reset), .in_valid(v11_ff), .in_ctx(c11_ff),
      .in_a(c11_ff.z2), .in_b(c11_ff.z2),
      .out_valid(v12), .out_ctx(c12), .out_p(sq12)
   );

   always_comb begin
      c13_in = c12;
      c13_in.s2 = svbs_pkg::clampw((WW+1)'(sq12) + (WW+1)'(c12.p4));
   end

   svbs_sqrt u_sq2 (
      .clock(clock), .reset(reset), .in_valid(v13_ff), .in_ctx(c13_ff),
      .in_x(c13_ff.s2), .out_valid(v14), .out_ctx(c14), .out_r(rad14)
   );

   // Pick the equal-radii or the unequal-radii answer.
   always_comb begin
      c15_in = c14;
      c15_in.rad = c14.eq ? $signed(WW'(c14.half)) : rad14;
      c15_in.travel = c14.eq ? c14.eqdist : c14.travel;
   end

   svbs_mul u_m5x (
      .clock(clock), .reset(reset), .in_valid(v15_ff), .in_ctx(c15_ff),
      .in_a(WW'($signed(c15_ff.dir[0]))), .in_b(c15_ff.travel),
      .out_valid(v16), .out_ctx(c16), .out_p(px)
   );
   svbs_mul u_m5y (
      .clock(clock), .reset(reset), .in_valid(v15_ff), .in_ctx(c15_ff),
      .in_a(WW'($signed(c15_ff.dir[1]))), .in_b(c15_ff.travel),
      .out_valid(), .out_ctx(), .out_p(py)
   );
   svbs_mul u_m5z (
      .clock(clock), .reset(reset), .in_valid(v15_ff), .in_ctx(c15_ff),
      .in_a(WW'($signed(c15_ff.dir[2]))), .in_b(c15_ff.travel),
      .out_valid(), .out_ctx(), .out_p(pz)
   );

   // A degenerate frustum returns the cast origin and the largest radius.
   always_comb begin
      if (c16.degen) begin
         cx_in = $signed(c16.org[0]);
         cy_in = $signed(c16.org[1]);
         cz_in = $signed(c16.org[2]);
      end else begin
         cx_in = sat32((WW+1)'($signed(c16.org[0])) + (WW+1)'(px));
         cy_in = sat32((WW+1)'($signed(c16.org[1])) + (WW+1)'(py));
         cz_in = sat32((WW+1)'($signed(c16.org[2])) + (WW+1)'(pz));
      end
      if (c16.degen || c16.rad > svbs_pkg::RAD_MAX) begin
         rad_in = '1;
      end else if (c16.rad < 0) begin
         rad_in = '0;
      end else begin
         rad_in = c16.rad[30:0];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_center_x = cx_ff;
   assign rsp_center_y = cy_ff;
   assign rsp_center_z = cz_ff;
   assign rsp_sphere_radius = rad_ff;
   assign rsp_degenerate = degen_ff;

endmodule

/* sv/svbs_checker.sv */
module svbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [30:0] rsp_sphere_radius,
   input logic        rsp_degenerate
);

   // Every accepted request produces its result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(svbs_pkg::TOTAL_LAT) rsp_valid)
      else $error("request produced no result at the pipeline latency");

   // No result appears without a request accepted exactly one latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, svbs_pkg::TOTAL_LAT))
      else $error("result without a matching request");

   // A degenerate frustum always reports the saturated radius.
   a_degen_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (&rsp_sphere_radius))
      else $error("degenerate result with unsaturated radius");

endmodule

bind shadow_volume_bounding_sphere svbs_checker u_svbs_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_sphere_radius(rsp_sphere_radius),
   .rsp_degenerate(rsp_degenerate)
);
